@@ hw/rtl/fbpa_pkg.sv @@
package fbpa_pkg;

   localparam int ADDR_W     = 32;
   localparam int SIZE_W     = 17;
   localparam int COUNT_W    = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_EMPTY       = 3'd1;
   localparam logic [2:0] ST_NOT_OWNED   = 3'd2;
   localparam logic [2:0] ST_DOUBLE_FREE = 3'd3;
   localparam logic [2:0] ST_OVERFLOW    = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_SIZE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DFREE_CHECK = 2'd3;

   localparam logic [ADDR_W-1:0]  BASE_RESET  = 32'd0;
   localparam logic [SIZE_W-1:0]  SIZE_RESET  = 17'd8;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
   localparam logic [SIZE_W-1:0]  SIZE_MIN    = 17'd8;
   localparam logic [SIZE_W-1:0]  SIZE_MAX    = 17'h10000;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [ADDR_W-1:0] slot_address;
   } req_payload_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  granted_address;
      logic [2:0]         status;
      logic               is_owned;
      logic               out_of_memory;
      logic [COUNT_W-1:0] allocations_now;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [ADDR_W-1:0] slot_address;
   } qent_type;

endpackage

@@ hw/rtl/fixed_block_pool_allocator.sv @@
// Fixed-size block pool allocator: hands out equal-sized slots of a pool as a
// LIFO free list (freed slots first, then never-used slots in ascending order),
// checks frees for range and alignment, optionally rejects double frees, and
// answers owner queries. Requests enter a two-entry queue and are executed one
// at a time by a sequencer with a shared 17 x log2(MAX_SLOTS) multiplier. An
// allocate that reuses a freed slot first reads its index from the stack. A
// free inside the pool runs the one-bit-per-cycle divider that turns the
// address offset into a slot index. Each response sits in an output register,
// so the queue keeps accepting while it waits. Writing any CSR empties the
// pool at once; no clearing pass is needed after reset or a CSR write.
module fixed_block_pool_allocator #(
   parameter int MAX_SLOTS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  fbpa_pkg::req_payload_type         req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output fbpa_pkg::rsp_payload_type         rsp_payload,
   input  logic                              csr_we,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fbpa_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic               q_valid;
   logic               q_pop;
   fbpa_pkg::qent_type q_head;

   fbpa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_head      (q_head)
   );

   fbpa_back #(.MAX_SLOTS(MAX_SLOTS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_head      (q_head),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

endmodule

@@ hw/rtl/fbpa_front.sv @@
module fbpa_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  fbpa_pkg::req_payload_type  req_payload,
   output logic                       q_valid,
   input  logic                       q_pop,
   output fbpa_pkg::qent_type         q_head
);

   localparam int DEPTH = 2;
   localparam int PTR_W = 1;
   localparam int CNT_W = 2;

   fbpa_pkg::qent_type ent_ff [DEPTH];
   fbpa_pkg::qent_type entry_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               push;

   assign req_ready = fill_ff != CNT_W'(DEPTH);
   assign push      = req_valid && req_ready;
   assign q_valid   = fill_ff != '0;
   assign q_head    = ent_ff[rd_ptr_ff];

   always_comb begin
      entry_in.slot_address = req_payload.slot_address;
      case (req_payload.cmd)
         fbpa_pkg::CMD_ALLOC: entry_in.op = fbpa_pkg::OP_ALLOC;
         fbpa_pkg::CMD_FREE:  entry_in.op = fbpa_pkg::OP_FREE;
         fbpa_pkg::CMD_QUERY: entry_in.op = fbpa_pkg::OP_QUERY;
         default:             entry_in.op = fbpa_pkg::OP_NONE;
      endcase
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      case ({push, q_pop})
         2'b10:   fill_in = fill_ff + CNT_W'(1);
         2'b01:   fill_in = fill_ff - CNT_W'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         ent_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

@@ hw/rtl/fbpa_div.sv @@
module fbpa_div #(
   parameter int IDX_W = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fbpa_pkg::ADDR_W-1:0]   dividend,
   input  logic [fbpa_pkg::SIZE_W-1:0]   divisor,
   output logic                          done,
   output logic [IDX_W-1:0]              quotient,
   output logic [fbpa_pkg::ADDR_W-1:0]   remainder
);

   localparam int SH_W  = fbpa_pkg::SIZE_W + IDX_W - 1;
   localparam int CMP_W = (SH_W > fbpa_pkg::ADDR_W) ? SH_W : fbpa_pkg::ADDR_W;
   localparam int CW    = $clog2(IDX_W + 1);

   logic [fbpa_pkg::ADDR_W-1:0] rem_ff, rem_in;
   logic [SH_W-1:0]             sh_ff, sh_in;
   logic [IDX_W-1:0]            quot_ff, quot_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic                        busy_ff, busy_in, done_ff, done_in;
   logic                        ge;
   logic [CMP_W-1:0]            diff;

   assign ge        = CMP_W'(rem_ff) >= CMP_W'(sh_ff);
   assign diff      = CMP_W'(rem_ff) - CMP_W'(sh_ff);
   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

   // restoring division, one quotient bit per cycle; the offset is known
   // to stay below divisor << IDX_W
   always_comb begin
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         sh_in   = SH_W'(divisor) << (IDX_W - 1);
         quot_in = '0;
         cnt_in  = CW'(IDX_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? fbpa_pkg::ADDR_W'(diff) : rem_ff;
         sh_in   = sh_ff >> 1;
         quot_in = IDX_W'({quot_ff, ge});
         cnt_in  = cnt_ff - CW'(1);
         busy_in = cnt_ff != CW'(1);
         done_in = cnt_ff == CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      sh_ff   <= sh_in;
      quot_ff <= quot_in;
   end

endmodule

@@ hw/rtl/fbpa_back.sv @@
module fbpa_back #(
   parameter int MAX_SLOTS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   output logic                              q_pop,
   input  fbpa_pkg::qent_type                q_head,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output fbpa_pkg::rsp_payload_type         rsp_payload,
   input  logic                              csr_we,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fbpa_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IDX_W  = $clog2(MAX_SLOTS);
   localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
   localparam int PROD_W = fbpa_pkg::SIZE_W + IDX_W;
   localparam int SUM_W  = ((PROD_W > fbpa_pkg::ADDR_W) ? PROD_W : fbpa_pkg::ADDR_W) + 1;
   localparam int AW     = fbpa_pkg::ADDR_W;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_A_POP  = 4'd1;
   localparam logic [3:0] S_MUL    = 4'd2;
   localparam logic [3:0] S_A_ADD  = 4'd3;
   localparam logic [3:0] S_RANGE  = 4'd4;
   localparam logic [3:0] S_DIV    = 4'd5;
   localparam logic [3:0] S_F_EXEC = 4'd6;
   localparam logic [3:0] S_RESP   = 4'd7;

   logic [3:0]                    state_ff, state_in;
   logic [1:0]                    op_ff, op_in;
   logic [AW-1:0]                 addr_ff, addr_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [PROD_W-1:0]             prod_ff, prod_in;
   logic [CNT_W-1:0]              depth_ff, depth_in, fresh_ff, fresh_in, live_ff, live_in;
   logic [AW-1:0]                 granted_ff, granted_in;
   logic [2:0]                    status_ff, status_in;
   logic                          owned_ff, owned_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   fbpa_pkg::rsp_payload_type     rsp_ff, rsp_in;
   logic [AW-1:0]                 base_ff, base_in;
   logic [fbpa_pkg::SIZE_W-1:0]   size_ff, size_in;
   logic [fbpa_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                          check_ff, check_in;

   logic [IDX_W-1:0]              stack_ram_ff [MAX_SLOTS];
   logic                          flag_ram_ff [MAX_SLOTS];
   logic [IDX_W-1:0]              stk_rd_ff;
   logic                          flag_rd_ff;

   logic                          stk_re, stk_we, flag_re, flag_we, flag_wdata;
   logic [IDX_W-1:0]              stk_raddr, flag_raddr;

   logic [fbpa_pkg::SIZE_W-1:0]   eff_size;
   logic [CNT_W-1:0]              eff_n;
   logic [IDX_W-1:0]              mul_opnd;
   logic [SUM_W-1:0]              last_addr;
   logic                          in_range, out_free, flag_now;

   logic                          div_start, div_done;
   logic [IDX_W-1:0]              div_quot;
   logic [AW-1:0]                 div_rem;

   fbpa_div #(.IDX_W(IDX_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (addr_ff - base_ff),
      .divisor   (eff_size),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   always_comb begin
      if (size_ff < fbpa_pkg::SIZE_MIN) begin
         eff_size = fbpa_pkg::SIZE_MIN;
      end else if (size_ff > fbpa_pkg::SIZE_MAX) begin
         eff_size = fbpa_pkg::SIZE_MAX;
      end else begin
         eff_size = size_ff;
      end
      eff_n = (32'(count_ff) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(count_ff);
   end

   assign mul_opnd  = (op_ff == fbpa_pkg::OP_ALLOC) ? idx_ff : IDX_W'(eff_n - CNT_W'(1));
   assign last_addr = SUM_W'(base_ff) + SUM_W'(prod_ff);
   assign in_range  = (eff_n != '0) && (addr_ff >= base_ff) && (SUM_W'(addr_ff) <= last_addr);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // slots at or above the fresh mark were never handed out since the pool was emptied
   assign flag_now  = (CNT_W'(idx_ff) < fresh_ff) && flag_rd_ff;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      idx_in       = idx_ff;
      prod_in      = prod_ff;
      depth_in     = depth_ff;
      fresh_in     = fresh_ff;
      live_in      = live_ff;
      granted_in   = granted_ff;
      status_in    = status_ff;
      owned_in     = owned_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      base_in      = base_ff;
      size_in      = size_ff;
      count_in     = count_ff;
      check_in     = check_ff;
      q_pop        = 1'b0;
      stk_re       = 1'b0;
      stk_raddr    = IDX_W'(depth_ff - CNT_W'(1));
      stk_we       = 1'b0;
      flag_re      = 1'b0;
      flag_raddr   = div_quot;
      flag_we      = 1'b0;
      flag_wdata   = 1'b0;
      div_start    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop      = 1'b1;
               op_in      = q_head.op;
               addr_in    = q_head.slot_address;
               granted_in = '0;
               status_in  = fbpa_pkg::ST_OK;
               owned_in   = 1'b0;
               case (q_head.op)
                  fbpa_pkg::OP_ALLOC: begin
                     if (depth_ff != '0) begin
                        stk_re   = 1'b1;
                        depth_in = depth_ff - CNT_W'(1);
                        live_in  = live_ff + CNT_W'(1);
                        state_in = S_A_POP;
                     end else if (fresh_ff < eff_n) begin
                        idx_in   = IDX_W'(fresh_ff);
                        fresh_in = fresh_ff + CNT_W'(1);
                        live_in  = live_ff + CNT_W'(1);
                        state_in = S_MUL;
                     end else begin
                        status_in = fbpa_pkg::ST_EMPTY;
                        state_in  = S_RESP;
                     end
                  end
                  fbpa_pkg::OP_FREE, fbpa_pkg::OP_QUERY: state_in = S_MUL;
                  default:                              state_in = S_RESP;
               endcase
            end
         end
         S_A_POP: begin
            idx_in   = stk_rd_ff;
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = PROD_W'(eff_size) * PROD_W'(mul_opnd);
            state_in = (op_ff == fbpa_pkg::OP_ALLOC) ? S_A_ADD : S_RANGE;
         end
         S_A_ADD: begin
            granted_in = base_ff + AW'(prod_ff);
            flag_we    = 1'b1;
            flag_wdata = 1'b1;
            state_in   = S_RESP;
         end
         S_RANGE: begin
            owned_in = in_range;
            if (op_ff == fbpa_pkg::OP_QUERY || !in_range) begin
               status_in = in_range ? fbpa_pkg::ST_OK : fbpa_pkg::ST_NOT_OWNED;
               state_in  = S_RESP;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (div_rem != '0) begin
                  status_in = fbpa_pkg::ST_NOT_OWNED;
                  state_in  = S_RESP;
               end else begin
                  idx_in   = div_quot;
                  flag_re  = 1'b1;
                  state_in = S_F_EXEC;
               end
            end
         end
         S_F_EXEC: begin
            if (check_ff && !flag_now) begin
               status_in = fbpa_pkg::ST_DOUBLE_FREE;
            end else if (live_ff == '0) begin
               status_in = fbpa_pkg::ST_OVERFLOW;
            end else begin
               stk_we     = 1'b1;
               flag_we    = 1'b1;
               flag_wdata = 1'b0;
               depth_in   = depth_ff + CNT_W'(1);
               live_in    = live_ff - CNT_W'(1);
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.granted_address = granted_ff;
               rsp_in.status          = status_ff;
               rsp_in.is_owned        = owned_ff;
               rsp_in.out_of_memory   = (depth_ff == '0) && (fresh_ff >= eff_n);
               rsp_in.allocations_now = fbpa_pkg::COUNT_W'(live_ff);
               state_in               = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_we) begin
         case (csr_index)
            fbpa_pkg::CSR_POOL_BASE:   base_in  = csr_wdata[AW-1:0];
            fbpa_pkg::CSR_SLOT_SIZE:   size_in  = csr_wdata[fbpa_pkg::SIZE_W-1:0];
            fbpa_pkg::CSR_SLOT_COUNT:  count_in = csr_wdata[fbpa_pkg::COUNT_W-1:0];
            fbpa_pkg::CSR_DFREE_CHECK: check_in = csr_wdata[0];
            default:                   check_in = check_ff;
         endcase
         depth_in = '0;
         fresh_in = '0;
         live_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         fresh_ff     <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= fbpa_pkg::BASE_RESET;
         size_ff      <= fbpa_pkg::SIZE_RESET;
         count_ff     <= fbpa_pkg::COUNT_RESET;
         check_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         fresh_ff     <= fresh_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         size_ff      <= size_in;
         count_ff     <= count_in;
         check_ff     <= check_in;
      end
      op_ff      <= op_in;
      addr_ff    <= addr_in;
      idx_ff     <= idx_in;
      prod_ff    <= prod_in;
      granted_ff <= granted_in;
      status_ff  <= status_in;
      owned_ff   <= owned_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_ram_ff[depth_ff[IDX_W-1:0]] <= idx_ff;
      end
      if (stk_re) begin
         stk_rd_ff <= stack_ram_ff[stk_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (flag_we) begin
         flag_ram_ff[idx_ff] <= flag_wdata;
      end
      if (flag_re) begin
         flag_rd_ff <= flag_ram_ff[flag_raddr];
      end
   end

endmodule
